@@ src/gaussian_sum_grid_generator_assert.svh @@
// Assertion macros used by the Gaussian grid generator top module.
`ifndef GAUSSIAN_SUM_GRID_GENERATOR_ASSERT_SVH
`define GAUSSIAN_SUM_GRID_GENERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define GSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define GSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GSG_ASSERT_NOW(lbl, ante, cons, msg)
`define GSG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/gsg_pkg.sv @@
// Shared constants, types and coefficient function of the Gaussian grid generator.
package gsg_pkg;

    localparam int GRID_SIZE  = 256;
    localparam int GRID_SHIFT = $clog2(GRID_SIZE);
    localparam int MAX_GAUSS  = 16;
    localparam int GIDX_W     = $clog2(MAX_GAUSS);
    localparam int CNT_W      = 5;
    localparam int COORD_W    = 14;
    localparam int EXP_BITS   = 20;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 40;
    localparam int APB_ADDR_W = 3;

    // Register index carried in paddr[2]
    localparam logic REG_ACTIVE_GAUSSIANS = 1'b0;

    // Command codes carried in tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef struct packed {
        logic       first;
        logic       last;
        logic [7:0] row;
        logic [7:0] col;
    } gsg_tag_t;

    typedef struct packed {
        gsg_tag_t             tag;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [15:0]          cx;
        logic [15:0]          cy;
        logic [15:0]          amp;
        logic [31:0]          invx;
        logic [31:0]          invy;
    } gsg_issue_t;

    typedef struct packed {
        gsg_tag_t            tag;
        logic [15:0]         amp;
        logic                zero;
        logic [EXP_BITS-1:0] e;
        logic [32:0]         acc;
    } gsg_exp_t;

    // Squared-power factor for exponent bit k: t_k = t_{k-1}^2 in Q0.32
    function automatic logic [31:0] exp_coef(input int k);
        logic [63:0] t;
        int          i;
        t = 64'hFFFF_0000;
        for (i = 0; i < k; i++)
        begin
            t = (t * t + 64'h8000_0000) >> 32;
        end
        return t[31:0];
    endfunction

endpackage

@@ src/gsg_recip.sv @@
// Iterative reciprocal of a squared width, Q16.16, one quotient bit per cycle.
module gsg_recip (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] width,
    output logic        done,
    output logic [31:0] quotient
);
    import gsg_pkg::*;

    typedef enum logic [2:0] {
        R_IDLE   = 3'b001,
        R_SQUARE = 3'b010,
        R_DIVIDE = 3'b100
    } recip_state_t;

    recip_state_t state_reg, state_next;
    logic [15:0]  s_reg;
    logic [31:0]  sq_reg, sq_next;
    logic [40:0]  num_reg, num_next;
    logic [31:0]  rem_reg, rem_next;
    logic [40:0]  q_reg, q_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         done_reg, done_next;
    logic [31:0]  sq_comb;
    logic [32:0]  rem_sh;
    logic [32:0]  rem_sub;

    assign sq_comb = s_reg * s_reg;
    assign rem_sh  = {rem_reg, num_reg[40]};
    assign rem_sub = rem_sh - {1'b0, sq_reg};

    // Step the square and then the restoring division
    always_comb
    begin
        state_next = state_reg;
        sq_next    = sq_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    state_next = R_SQUARE;
                end
            end
            R_SQUARE:
            begin
                sq_next    = sq_comb;
                num_next   = {1'b1, 40'd0} + {9'd0, sq_comb >> 1};
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = 6'd40;
                state_next = R_DIVIDE;
            end
            R_DIVIDE:
            begin
                if (rem_sh >= {1'b0, sq_reg})
                begin
                    rem_next = rem_sub[31:0];
                    q_next   = {q_reg[39:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    q_next   = {q_reg[39:0], 1'b0};
                end
                num_next = {num_reg[39:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    // Capture the clamped width on start
    always_ff @(posedge clk)
    begin
        if (start && state_reg == R_IDLE)
        begin
            s_reg <= (width == 16'd0) ? 16'd1 : width;
        end
        sq_reg  <= sq_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = (|q_reg[40:32]) ? 32'hFFFF_FFFF : q_reg[31:0];

endmodule

@@ src/gsg_exp_step.sv @@
// One registered stage of the exp(-e) product chain: multiply by one factor if its bit is set.
module gsg_exp_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  gsg_pkg::gsg_exp_t               in_data,
    input  logic [31:0]                     coef,
    input  logic [gsg_pkg::EXP_BITS-1:0]    sel_mask,
    output logic                            out_valid,
    output gsg_pkg::gsg_exp_t               out_data
);
    import gsg_pkg::*;

    logic       hit;
    logic [64:0] prod;
    logic [64:0] rounded;
    gsg_exp_t   data_next;
    logic       valid_reg;
    gsg_exp_t   data_reg;

    assign hit     = |(in_data.e & sel_mask);
    assign prod    = 65'(in_data.acc) * 65'(coef);
    assign rounded = prod + 65'h8000_0000;

    // Apply the factor when its exponent bit is set
    always_comb
    begin
        data_next = in_data;
        if (hit)
        begin
            data_next.acc = rounded[64:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ src/gsg_eval_pipe.sv @@
// Pipeline that turns one table entry at one grid point into a rounded Q8.8 term.
module gsg_eval_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  gsg_pkg::gsg_issue_t  in_data,
    output logic                 out_valid,
    output logic [17:0]          out_term,
    output gsg_pkg::gsg_tag_t    out_tag
);
    import gsg_pkg::*;

    // Stage 0: entry capture
    logic       s0_valid_reg;
    gsg_issue_t s0_reg;

    // Stage 1: absolute distances
    logic        s1_valid_reg;
    logic [15:0] s1_magx_reg, s1_magy_reg;
    logic [15:0] s1_amp_reg;
    logic [31:0] s1_invx_reg, s1_invy_reg;
    gsg_tag_t    s1_tag_reg;
    logic [17:0] dx, dy;

    // Stage 2: squared distances
    logic        s2_valid_reg;
    logic [31:0] s2_sqx_reg, s2_sqy_reg;
    logic [15:0] s2_amp_reg;
    logic [31:0] s2_invx_reg, s2_invy_reg;
    gsg_tag_t    s2_tag_reg;

    // Stage 3: scaled by reciprocal widths
    logic        s3_valid_reg;
    logic [63:0] s3_px_reg, s3_py_reg;
    logic [15:0] s3_amp_reg;
    gsg_tag_t    s3_tag_reg;

    // Stage 4: rounded axis terms and exponent sum
    logic        s4_valid_reg;
    gsg_exp_t    s4_reg;
    logic [64:0] rx_full, ry_full;
    logic [20:0] tx, ty;
    logic [21:0] e_sum;

    // Exponent chain
    logic     exp_valid [0:EXP_BITS];
    gsg_exp_t exp_data  [0:EXP_BITS];

    // Factor and term stages
    logic        sf_valid_reg;
    logic [16:0] sf_f_reg;
    logic [15:0] sf_amp_reg;
    gsg_tag_t    sf_tag_reg;
    logic [33:0] f_sum;
    logic        st_valid_reg;
    logic [17:0] st_term_reg;
    gsg_tag_t    st_tag_reg;
    logic signed [33:0] tprod;
    logic signed [34:0] tw;

    assign dx = {{(18-COORD_W){s0_reg.x[COORD_W-1]}}, s0_reg.x}
              - {{2{s0_reg.cx[15]}}, s0_reg.cx};
    assign dy = {{(18-COORD_W){s0_reg.y[COORD_W-1]}}, s0_reg.y}
              - {{2{s0_reg.cy[15]}}, s0_reg.cy};

    assign rx_full = ({1'b0, s3_px_reg} + 65'h80_0000) >> 24;
    assign ry_full = ({1'b0, s3_py_reg} + 65'h80_0000) >> 24;
    assign tx      = (rx_full > 65'h10_0000) ? 21'h10_0000 : rx_full[20:0];
    assign ty      = (ry_full > 65'h10_0000) ? 21'h10_0000 : ry_full[20:0];
    assign e_sum   = {1'b0, tx} + {1'b0, ty};

    assign f_sum = {1'b0, exp_data[EXP_BITS].acc} + 34'h8000;
    assign tprod = $signed(sf_amp_reg) * $signed({1'b0, sf_f_reg});
    assign tw    = 35'(tprod) + 35'sh8000;

    // Advance the payload of the fixed stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg      <= in_data;
            s1_magx_reg <= dx[17] ? 16'(-dx) : dx[15:0];
            s1_magy_reg <= dy[17] ? 16'(-dy) : dy[15:0];
            s1_amp_reg  <= s0_reg.amp;
            s1_invx_reg <= s0_reg.invx;
            s1_invy_reg <= s0_reg.invy;
            s1_tag_reg  <= s0_reg.tag;
            s2_sqx_reg  <= s1_magx_reg * s1_magx_reg;
            s2_sqy_reg  <= s1_magy_reg * s1_magy_reg;
            s2_amp_reg  <= s1_amp_reg;
            s2_invx_reg <= s1_invx_reg;
            s2_invy_reg <= s1_invy_reg;
            s2_tag_reg  <= s1_tag_reg;
            s3_px_reg   <= 64'(s2_sqx_reg) * 64'(s2_invx_reg);
            s3_py_reg   <= 64'(s2_sqy_reg) * 64'(s2_invy_reg);
            s3_amp_reg  <= s2_amp_reg;
            s3_tag_reg  <= s2_tag_reg;
            s4_reg.tag  <= s3_tag_reg;
            s4_reg.amp  <= s3_amp_reg;
            s4_reg.zero <= (e_sum >= 22'h10_0000);
            s4_reg.e    <= e_sum[EXP_BITS-1:0];
            s4_reg.acc  <= 33'h1_0000_0000;
            sf_f_reg    <= exp_data[EXP_BITS].zero ? 17'd0 : f_sum[32:16];
            sf_amp_reg  <= exp_data[EXP_BITS].amp;
            sf_tag_reg  <= exp_data[EXP_BITS].tag;
            st_term_reg <= 18'(tw >>> 16);
            st_tag_reg  <= sf_tag_reg;
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            sf_valid_reg <= 1'b0;
            st_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            sf_valid_reg <= exp_valid[EXP_BITS];
            st_valid_reg <= sf_valid_reg;
        end
    end

    assign exp_valid[0] = s4_valid_reg;
    assign exp_data[0]  = s4_reg;

    // One product stage per exponent bit
    for (genvar k = 0; k < EXP_BITS; k++)
    begin : g_exp
        localparam logic [31:0] COEF = exp_coef(k);
        gsg_exp_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (exp_valid[k]),
            .in_data   (exp_data[k]),
            .coef      (COEF),
            .sel_mask  (EXP_BITS'(1) << k),
            .out_valid (exp_valid[k+1]),
            .out_data  (exp_data[k+1])
        );
    end

    assign out_valid = st_valid_reg;
    assign out_term  = st_term_reg;
    assign out_tag   = st_tag_reg;

endmodule

@@ src/gaussian_sum_grid_generator.sv @@
// Sum-of-Gaussians grid generator: a load item fills one of 16 table entries (center,
// amplitude, reciprocal squared widths); a render item returns the sum over the first
// active_gaussians entries at the grid point, one word per render item, none per load.
// A render item holds the input while its entries issue (at least one, at most 16), one
// table entry entering the 27-stage evaluation pipeline per cycle while the output is
// not stalled; its word is presented once the last entry's term has been added. A load
// item holds the input until the bit-serial reciprocal divider (41 quotient bits) ends. A stalled output
// word freezes the whole pipeline. Entries that were never loaded must not be summed.
module gaussian_sum_grid_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: entry_index, center_x, center_y, amplitude, width_x, width_y,
    //        grid_row, grid_col (from bit 0 up), zero filled to 104 bits
    input  logic [gsg_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: command
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pixel_value, out_row, out_col (from bit 0 up), zero filled to 40 bits
    output logic [gsg_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gsg_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import gsg_pkg::*;
    `include "gaussian_sum_grid_generator_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RENDER = 3'b010,
        ST_LOAD   = 3'b100
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [CNT_W-1:0]  active_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [GIDX_W-1:0] k_reg;
    logic [7:0]        row_reg, col_reg;
    logic [GIDX_W-1:0] slot_reg;
    logic              slot_ok_reg;
    logic [15:0]       cx_hold_reg, cy_hold_reg, amp_hold_reg;

    logic [15:0] cx_table  [0:MAX_GAUSS-1];
    logic [15:0] cy_table  [0:MAX_GAUSS-1];
    logic [15:0] amp_table [0:MAX_GAUSS-1];
    logic [31:0] invx_table [0:MAX_GAUSS-1];
    logic [31:0] invy_table [0:MAX_GAUSS-1];

    logic        in_fire, out_fire, en;
    logic        in_cmd;
    logic [3:0]  in_idx;
    logic [15:0] in_cx, in_cy, in_amp, in_wx, in_wy;
    logic [7:0]  in_row, in_col;
    logic [CNT_W-1:0] n_clamped;
    logic        issue_valid, issue_last, issue_none;
    gsg_issue_t  issue;
    logic        rx_done, ry_done;
    logic [31:0] rx_q, ry_q;
    logic        tail_valid;
    logic [17:0] tail_term;
    gsg_tag_t    tail_tag;
    logic signed [20:0] sum_reg;
    logic signed [21:0] sum_wide;
    logic signed [20:0] sum_sat;
    logic        out_valid_reg;
    logic [20:0] out_pix_reg;
    logic [7:0]  out_row_reg, out_col_reg;
    logic        cfg_write;

    // Unpack the input word
    assign in_cmd = s_axis_tuser;
    assign in_idx = s_axis_tdata[3:0];
    assign in_cx  = s_axis_tdata[19:4];
    assign in_cy  = s_axis_tdata[35:20];
    assign in_amp = s_axis_tdata[51:36];
    assign in_wx  = s_axis_tdata[67:52];
    assign in_wy  = s_axis_tdata[83:68];
    assign in_row = s_axis_tdata[91:84];
    assign in_col = s_axis_tdata[99:92];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign en            = !out_valid_reg || m_axis_tready;
    assign n_clamped     = (32'(active_reg) > MAX_GAUSS) ? CNT_W'(MAX_GAUSS) : active_reg;

    // Build one table entry for the pipeline; an empty run sends a zero entry
    assign issue_none  = (n_reg == '0);
    assign issue_last  = issue_none || ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg);
    assign issue_valid = (state_reg == ST_RENDER);
    always_comb
    begin
        issue.tag.first = (k_reg == '0);
        issue.tag.last  = issue_last;
        issue.tag.row   = row_reg;
        issue.tag.col   = col_reg;
        issue.x    = COORD_W'(20'(row_reg) * 20'd4096 >> GRID_SHIFT) - COORD_W'(2048);
        issue.y    = COORD_W'(20'(col_reg) * 20'd4096 >> GRID_SHIFT) - COORD_W'(2048);
        issue.cx   = issue_none ? 16'd0 : cx_table[k_reg];
        issue.cy   = issue_none ? 16'd0 : cy_table[k_reg];
        issue.amp  = issue_none ? 16'd0 : amp_table[k_reg];
        issue.invx = issue_none ? 32'd0 : invx_table[k_reg];
        issue.invy = issue_none ? 32'd0 : invy_table[k_reg];
    end

    // Sequence render entries and loads
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_cmd == CMD_RENDER) ? ST_RENDER : ST_LOAD;
                end
            end
            ST_RENDER:
            begin
                if (en && issue_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                if (rx_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                active_reg <= pwdata[CNT_W-1:0];
            end
            if (in_fire)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_RENDER && en)
            begin
                k_reg <= k_reg + GIDX_W'(1);
            end
        end
    end

    // Hold the item fields
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            n_reg        <= n_clamped;
            row_reg      <= in_row;
            col_reg      <= in_col;
            slot_reg     <= in_idx[GIDX_W-1:0];
            slot_ok_reg  <= (32'(in_idx) < MAX_GAUSS);
            cx_hold_reg  <= in_cx;
            cy_hold_reg  <= in_cy;
            amp_hold_reg <= in_amp;
        end
    end

    // Write the table entry once both reciprocals are ready
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && rx_done && slot_ok_reg)
        begin
            cx_table[slot_reg]   <= cx_hold_reg;
            cy_table[slot_reg]   <= cy_hold_reg;
            amp_table[slot_reg]  <= amp_hold_reg;
            invx_table[slot_reg] <= rx_q;
            invy_table[slot_reg] <= ry_q;
        end
    end

    gsg_recip u_recip_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire && in_cmd == CMD_LOAD),
        .width    (in_wx),
        .done     (rx_done),
        .quotient (rx_q)
    );

    gsg_recip u_recip_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire && in_cmd == CMD_LOAD),
        .width    (in_wy),
        .done     (ry_done),
        .quotient (ry_q)
    );

    gsg_eval_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (issue_valid),
        .in_data   (issue),
        .out_valid (tail_valid),
        .out_term  (tail_term),
        .out_tag   (tail_tag)
    );

    // Accumulate terms with saturation
    assign sum_wide = (tail_tag.first ? 22'sd0 : 22'(sum_reg)) + 22'($signed(tail_term));
    always_comb
    begin
        if (sum_wide > 22'sd1048575)
        begin
            sum_sat = 21'sd1048575;
        end
        else if (sum_wide < -22'sd1048576)
        begin
            sum_sat = -21'sd1048576;
        end
        else
        begin
            sum_sat = 21'(sum_wide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tail_valid)
        begin
            sum_reg <= sum_sat;
            if (tail_tag.last)
            begin
                out_pix_reg <= sum_sat;
                out_row_reg <= tail_tag.row;
                out_col_reg <= tail_tag.col;
            end
        end
    end

    // Present the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && tail_valid && tail_tag.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_col_reg, out_row_reg, out_pix_reg};

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_GAUSSIANS);
    assign prdata    = (paddr[2] == REG_ACTIVE_GAUSSIANS) ? {27'd0, active_reg} : 32'd0;

    `GSG_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "input accepted while busy")
    `GSG_ASSERT_NOW(a_recip_lockstep, state_reg == ST_LOAD && rx_done, ry_done,
                    "reciprocal lanes out of step")
    `GSG_ASSERT_NOW(a_index_in_run, state_reg == ST_RENDER,
                    (CNT_W'(k_reg) < n_reg) || (n_reg == '0), "render index past run")
    `GSG_ASSERT_NEXT(a_last_emits, en && tail_valid && tail_tag.last, m_axis_tvalid,
                     "final term produced no word")

endmodule
